// File: hdl/ipv6_text_address_parser_macros.svh
// Assertion helpers shared by the parser modules.
// Each macro samples on the rising clock edge and is disabled during reset.
`ifndef IPV6_TEXT_ADDRESS_PARSER_MACROS_SVH
`define IPV6_TEXT_ADDRESS_PARSER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TAP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TAP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/ipv6_tap_pkg.sv
package ipv6_tap_pkg;

   localparam logic [3:0] GroupsFull   = 4'd8;
   localparam logic [3:0] NoGap        = 4'd8;
   localparam logic [2:0] DigitsMax    = 3'd4;
   localparam logic [1:0] ColonsDouble = 2'd2;

   localparam logic [7:0] CharZero  = 8'h30;
   localparam logic [7:0] CharNine  = 8'h39;
   localparam logic [7:0] CharColon = 8'h3A;
   localparam logic [7:0] CharUpA   = 8'h41;
   localparam logic [7:0] CharUpF   = 8'h46;
   localparam logic [7:0] CharLowA  = 8'h61;
   localparam logic [7:0] CharLowF  = 8'h66;

   typedef logic [7:0][15:0] group_vec_type;

   // Snapshot handed from the character step to the address assembly.
   typedef struct packed {
      logic        valid;
      logic        fail;
      logic        stop;
      logic [3:0]  count;
      logic [3:0]  gap;
      logic [2:0]  digits;
      logic [15:0] accum;
   } finish_req_type;

endpackage

// File: hdl/ipv6_text_address_parser.sv
// Path: an accepted character is held in the input register, and a response that it completes
// is captured from there in the response register.
// Throughput: one character per cycle while no held response stalls the output; the per-character
// step and the group expansion both sit between the input register and the response register.
// Reset: synchronous, active high; clears the parse state and empties both registers.
`include "ipv6_text_address_parser_macros.svh"

module ipv6_text_address_parser (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] char_code
   input  logic         req_tlast,   // end_of_text
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // [63:0] addr_upper, [127:64] addr_lower
   output logic [1:0]   rsp_tuser    // [0] parse_ok, [1] stopped_at_char
);
   import ipv6_tap_pkg::*;

   logic          in_valid_ff, in_valid_in;
   logic [7:0]    in_char_ff, in_char_in;
   logic          in_eot_ff, in_eot_in;
   logic          out_valid_ff, out_valid_in;
   logic          out_ok_ff, out_ok_in;
   logic          out_stop_ff, out_stop_in;
   logic [63:0]   out_upper_ff, out_upper_in;
   logic [63:0]   out_lower_ff, out_lower_in;

   logic           advance;
   logic           go;
   finish_req_type fin;
   group_vec_type  fin_store;
   logic           ok;
   logic [63:0]    upper;
   logic [63:0]    lower;

   assign advance    = !out_valid_ff || rsp_tready;
   assign go         = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   ipv6_tap_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .go          (go),
      .char_code   (in_char_ff),
      .end_of_text (in_eot_ff),
      .fin         (fin),
      .fin_store   (fin_store)
   );

   ipv6_tap_expand u_expand (
      .fin       (fin),
      .fin_store (fin_store),
      .ok        (ok),
      .upper     (upper),
      .lower     (lower)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_char_in  = in_char_ff;
      in_eot_in   = in_eot_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_char_in  = req_tdata;
         in_eot_in   = req_tlast;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      out_ok_in    = out_ok_ff;
      out_stop_in  = out_stop_ff;
      out_upper_in = out_upper_ff;
      out_lower_in = out_lower_ff;
      if (advance) begin
         out_valid_in = go && fin.valid;
         out_ok_in    = ok;
         out_stop_in  = fin.stop;
         out_upper_in = upper;
         out_lower_in = lower;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_char_ff   <= in_char_in;
      in_eot_ff    <= in_eot_in;
      out_ok_ff    <= out_ok_in;
      out_stop_ff  <= out_stop_in;
      out_upper_ff <= out_upper_in;
      out_lower_ff <= out_lower_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_lower_ff, out_upper_ff};
   assign rsp_tuser  = {out_stop_ff, out_ok_ff};

   `TAP_ASSERT_NOW(a_fail_zero, out_valid_ff && !out_ok_ff, out_upper_ff == 64'd0 && out_lower_ff == 64'd0, "failed parse carries a nonzero address")
   `TAP_ASSERT_NEXT(a_in_held, in_valid_ff && !advance, in_valid_ff && $stable(in_char_ff) && $stable(in_eot_ff), "stalled request lost from input register")
   `TAP_ASSERT_NEXT(a_out_held, out_valid_ff && !rsp_tready, out_valid_ff && $stable(out_upper_ff) && $stable(out_ok_ff), "stalled response lost from output register")

endmodule

// File: hdl/ipv6_tap_expand.sv
module ipv6_tap_expand (
   input  ipv6_tap_pkg::finish_req_type fin,
   input  ipv6_tap_pkg::group_vec_type  fin_store,
   output logic                         ok,
   output logic [63:0]                  upper,
   output logic [63:0]                  lower
);
   import ipv6_tap_pkg::*;

   group_vec_type fstore;
   group_vec_type g;
   logic [3:0]    n;
   logic [3:0]    nz;
   logic          gap_ok;

   always_comb begin
      fstore = fin_store;
      n      = fin.count;
      if (fin.digits != 3'd0 && fin.count < GroupsFull) begin
         fstore[fin.count[2:0]] = fin.accum;
         n = fin.count + 4'd1;
      end
   end

   assign gap_ok = (fin.gap < NoGap) && (fin.gap <= n);
   assign nz     = GroupsFull - n;

   // The double colon opens a run of zero groups; the groups after it slide to the end.
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         if (gap_ok && 4'(i) >= fin.gap
             && {1'b0, 4'(i)} < ({1'b0, fin.gap} + {1'b0, nz})) begin
            g[i] = 16'd0;
         end else if (gap_ok && 4'(i) >= fin.gap) begin
            g[i] = fstore[3'(i) - nz[2:0]];
         end else begin
            g[i] = fstore[i];
         end
      end
   end

   assign ok    = !fin.fail && (gap_ok || n == GroupsFull);
   assign upper = ok ? {g[0], g[1], g[2], g[3]} : 64'd0;
   assign lower = ok ? {g[4], g[5], g[6], g[7]} : 64'd0;

endmodule

// File: hdl/ipv6_tap_parse.sv
`include "ipv6_text_address_parser_macros.svh"

module ipv6_tap_parse (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         go,
   input  logic [7:0]                   char_code,
   input  logic                         end_of_text,
   output ipv6_tap_pkg::finish_req_type fin,
   output ipv6_tap_pkg::group_vec_type  fin_store
);
   import ipv6_tap_pkg::*;

   group_vec_type store_ff, store_in;
   logic [3:0]    count_ff, count_in;
   logic [15:0]   accum_ff, accum_in;
   logic [2:0]    digits_ff, digits_in;
   logic [1:0]    colons_ff, colons_in;
   logic [3:0]    gap_ff, gap_in;
   logic          skip_ff, skip_in;

   logic          is_num;
   logic          is_hex;
   logic          is_colon;
   logic [3:0]    digit_val;
   logic          clear_w;

   assign is_num   = char_code >= CharZero && char_code <= CharNine;
   assign is_hex   = is_num
                     || (char_code >= CharLowA && char_code <= CharLowF)
                     || (char_code >= CharUpA && char_code <= CharUpF);
   assign is_colon = char_code == CharColon && colons_ff < ColonsDouble;
   // Letters a-f and A-F carry 1 to 6 in their low nibble.
   assign digit_val = is_num ? char_code[3:0] : char_code[3:0] + 4'd9;

   always_comb begin
      store_in  = store_ff;
      count_in  = count_ff;
      accum_in  = accum_ff;
      digits_in = digits_ff;
      colons_in = colons_ff;
      gap_in    = gap_ff;
      skip_in   = skip_ff;
      clear_w   = 1'b0;
      fin       = '0;
      if (go) begin
         if (skip_ff) begin
            if (end_of_text) begin
               skip_in = 1'b0;
            end
         end else if (!is_hex && !is_colon) begin
            fin.valid = 1'b1;
            fin.stop  = 1'b1;
            clear_w   = 1'b1;
         end else begin
            colons_in = colons_ff + 2'(is_colon);
            if (count_ff >= GroupsFull) begin
               fin.valid = 1'b1;
               fin.fail  = 1'b1;
               clear_w   = 1'b1;
            end else if (is_hex && digits_ff >= DigitsMax) begin
               fin.valid = 1'b1;
               fin.fail  = 1'b1;
               clear_w   = 1'b1;
            end else begin
               if (is_hex) begin
                  accum_in  = {accum_ff[11:0], digit_val};
                  colons_in = 2'd0;
                  digits_in = digits_ff + 3'd1;
               end
               if (colons_in == ColonsDouble && gap_ff != NoGap) begin
                  fin.valid = 1'b1;
                  fin.fail  = 1'b1;
                  clear_w   = 1'b1;
               end else begin
                  if (colons_in == ColonsDouble) begin
                     gap_in = count_ff;
                  end
                  if (colons_in != 2'd0 && digits_in != 3'd0) begin
                     store_in[count_ff[2:0]] = accum_in;
                     count_in  = count_ff + 4'd1;
                     accum_in  = 16'd0;
                     digits_in = 3'd0;
                  end
                  if (end_of_text) begin
                     fin.valid = 1'b1;
                     clear_w   = 1'b1;
                  end
               end
            end
         end
      end
      fin.count  = count_in;
      fin.gap    = gap_in;
      fin.digits = digits_in;
      fin.accum  = accum_in;
      fin_store  = store_in;
      if (clear_w) begin
         store_in  = '0;
         count_in  = 4'd0;
         accum_in  = 16'd0;
         digits_in = 3'd0;
         colons_in = 2'd0;
         gap_in    = NoGap;
         skip_in   = !end_of_text;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         store_ff  <= '0;
         count_ff  <= 4'd0;
         accum_ff  <= 16'd0;
         digits_ff <= 3'd0;
         colons_ff <= 2'd0;
         gap_ff    <= NoGap;
         skip_ff   <= 1'b0;
      end else begin
         store_ff  <= store_in;
         count_ff  <= count_in;
         accum_ff  <= accum_in;
         digits_ff <= digits_in;
         colons_ff <= colons_in;
         gap_ff    <= gap_in;
         skip_ff   <= skip_in;
      end
   end

   `TAP_ASSERT_NOW(a_bounds, 1'b1, count_ff <= GroupsFull && gap_ff <= NoGap, "group count or gap out of range")
   `TAP_ASSERT_NEXT(a_eot_clears, go && end_of_text, !skip_ff && count_ff == 4'd0 && digits_ff == 3'd0, "state not cleared after final character")
   `TAP_ASSERT_NOW(a_skip_clean, skip_ff, count_ff == 4'd0 && digits_ff == 3'd0 && colons_ff == 2'd0, "parse state not clear while skipping")

endmodule
